// ===== rtl/tlrb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrb_pkg: shared types and constants of the text line ring buffer
// Register indexes, character codes, operation codes and the structs that
// travel between the configuration, cursor, store and top level modules.
// ----------------------------------------------------------------------------
package tlrb_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LINE_LENGTH  = 8'd0;
  localparam logic [7:0] CFG_LINES_IN_USE = 8'd1;

  // Register reset values.
  localparam logic [7:0] LINE_LENGTH_RST  = 8'd80;
  localparam logic [6:0] LINES_IN_USE_RST = 7'd64;

  // Character codes.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_NUL     = 8'd0;

  // Operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Effective configuration, already clamped to the legal ranges.
  typedef struct packed {
    logic [7:0] eff_len;
    logic [6:0] eff_slots;
    logic       wr;
  } cfg_t;

  // Memory requests from the cursor logic to the store.
  typedef struct packed {
    logic       chr_we;
    logic [6:0] chr_slot;
    logic [7:0] chr_col;
    logic [7:0] chr_data;
    logic       len_we;
    logic [6:0] len_slot;
    logic [7:0] len_data;
    logic [6:0] rd_slot;
    logic [6:0] rd_col;
  } mem_req_t;

  // Result fields known before the store read returns.
  typedef struct packed {
    logic       idx_valid;
    logic [6:0] col;
    logic [6:0] visible;
    logic [7:0] cursor;
  } meta_t;

endpackage

// ===== rtl/tlrb_ifs.sv =====
// ----------------------------------------------------------------------------
// tlrb channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface tlrb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_in;
  logic [5:0] line_index;
  logic [6:0] column;

  modport source (output valid, output operation, output char_in, output line_index,
                  output column, input ready);
  modport sink   (input valid, input operation, input char_in, input line_index,
                  input column, output ready);
endinterface

interface tlrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       index_valid;
  logic [6:0] visible_lines;
  logic [7:0] cursor_column;

  modport source (output valid, output char_out, output index_valid,
                  output visible_lines, output cursor_column, input ready);
  modport sink   (input valid, input char_out, input index_valid,
                  input visible_lines, input cursor_column, output ready);
endinterface

interface tlrb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tlrb_cfg.sv =====
// ----------------------------------------------------------------------------
// tlrb_cfg: configuration registers
// Holds line length and slot count and presents them clamped to the range
// that the storage supports.
// ----------------------------------------------------------------------------
module tlrb_cfg #(
  parameter int MAX_LINE_LENGTH = 128,
  parameter int MAX_LINES       = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  tlrb_cfg_if.sink           cfg_ch,
  output tlrb_pkg::cfg_t     cfg
);

  logic [7:0] line_length_r;
  logic [6:0] lines_in_use_r;
  logic       wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r  <= tlrb_pkg::LINE_LENGTH_RST;
      lines_in_use_r <= tlrb_pkg::LINES_IN_USE_RST;
    end else if (wr) begin
      if (cfg_ch.index == tlrb_pkg::CFG_LINE_LENGTH) begin
        line_length_r <= cfg_ch.data;
      end else if (cfg_ch.index == tlrb_pkg::CFG_LINES_IN_USE) begin
        lines_in_use_r <= cfg_ch.data[6:0];
      end
    end
  end

  always_comb begin
    cfg.wr = wr;
    if (line_length_r == 8'd0) begin
      cfg.eff_len = 8'd1;
    end else if (int'(line_length_r) > MAX_LINE_LENGTH) begin
      cfg.eff_len = 8'(MAX_LINE_LENGTH);
    end else begin
      cfg.eff_len = line_length_r;
    end
    if (lines_in_use_r == 7'd0) begin
      cfg.eff_slots = 7'd1;
    end else if (int'(lines_in_use_r) > MAX_LINES) begin
      cfg.eff_slots = 7'(MAX_LINES);
    end else begin
      cfg.eff_slots = lines_in_use_r;
    end
  end

endmodule

// ===== rtl/tlrb_cursor.sv =====
// ----------------------------------------------------------------------------
// tlrb_cursor: write cursor and ring position
// Keeps column, slot and line count, decides wrap and newline handling and
// forms the store accesses for the item in the input register.
// ----------------------------------------------------------------------------
module tlrb_cursor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlrb_pkg::cfg_t       cfg,
  input  logic                 fire,
  input  logic                 operation,
  input  logic [7:0]           char_in,
  input  logic [5:0]           line_index,
  input  logic [6:0]           column,
  output tlrb_pkg::mem_req_t   req,
  output tlrb_pkg::meta_t      meta,
  output logic                 busy
);

  logic [7:0] wcol_r, wcol_nxt;
  logic [6:0] wslot_r, wslot_nxt;
  logic [6:0] wmod_r, wmod_nxt;   // write slot reduced modulo the slot count
  logic [6:0] total_r, total_nxt;
  logic [6:0] rem_r;
  logic       rcp_busy_r;

  logic [7:0] nl_s8;
  logic [6:0] nl_slot;
  logic [6:0] nl_total;
  logic [6:0] total_eff;
  logic [6:0] total_eff_nxt;
  logic [7:0] k8;
  logic [7:0] slot8;
  logic       wrap;
  logic [6:0] ap_slot;
  logic [7:0] ap_col;

  assign busy = rcp_busy_r;

  always_comb begin
    nl_s8    = {1'b0, wslot_r} + 8'd1;
    nl_slot  = (nl_s8 >= {1'b0, cfg.eff_slots}) ? 7'd0 : nl_s8[6:0];
    nl_total = (({1'b0, total_r} + 8'd1) < {1'b0, cfg.eff_slots}) ?
               (total_r + 7'd1) : cfg.eff_slots;
    total_eff = (total_r < cfg.eff_slots) ? total_r : cfg.eff_slots;

    // Logical line index 0 is the oldest visible line; the last visible index maps to the write slot.
    k8    = {1'b0, total_eff} - 8'd1 - {2'b00, line_index};
    slot8 = ({1'b0, wmod_r} >= k8) ? ({1'b0, wmod_r} - k8) :
            ({1'b0, wmod_r} + {1'b0, cfg.eff_slots} - k8);

    wrap    = (wcol_r >= cfg.eff_len) || (wslot_r >= cfg.eff_slots);
    ap_slot = wrap ? nl_slot : wslot_r;
    ap_col  = wrap ? 8'd0 : wcol_r;

    wcol_nxt  = wcol_r;
    wslot_nxt = wslot_r;
    wmod_nxt  = wmod_r;
    total_nxt = total_r;

    req.chr_we   = 1'b0;
    req.chr_slot = ap_slot;
    req.chr_col  = ap_col;
    req.chr_data = char_in;
    req.len_we   = 1'b0;
    req.len_slot = ap_slot;
    req.len_data = ap_col + 8'd1;
    req.rd_slot  = slot8[6:0];
    req.rd_col   = column;

    if (operation == tlrb_pkg::OP_APPEND) begin
      if (char_in == tlrb_pkg::CHAR_NEWLINE) begin
        wcol_nxt     = 8'd0;
        wslot_nxt    = nl_slot;
        wmod_nxt     = nl_slot;
        total_nxt    = nl_total;
        req.len_we   = fire;
        req.len_slot = nl_slot;
        req.len_data = 8'd0;
      end else if (char_in != tlrb_pkg::CHAR_NUL) begin
        wcol_nxt   = ap_col + 8'd1;
        wslot_nxt  = ap_slot;
        req.chr_we = fire;
        req.len_we = fire;
        if (wrap) begin
          wmod_nxt  = nl_slot;
          total_nxt = nl_total;
        end
      end
    end

    total_eff_nxt  = (total_nxt < cfg.eff_slots) ? total_nxt : cfg.eff_slots;
    meta.idx_valid = (operation == tlrb_pkg::OP_READ) &&
                     ({1'b0, line_index} < total_eff);
    meta.col       = column;
    meta.visible   = total_eff_nxt;
    meta.cursor    = wcol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r     <= 8'd0;
      wslot_r    <= 7'd0;
      wmod_r     <= 7'd0;
      total_r    <= 7'd1;
      rem_r      <= 7'd0;
      rcp_busy_r <= 1'b0;
    end else begin
      if (fire) begin
        wcol_r  <= wcol_nxt;
        wslot_r <= wslot_nxt;
        wmod_r  <= wmod_nxt;
        total_r <= total_nxt;
      end
      // After a register write the ring position is reduced by repeated
      // subtraction of the new slot count.
      if (cfg.wr) begin
        rcp_busy_r <= 1'b1;
        rem_r      <= wslot_r;
      end else if (rcp_busy_r) begin
        if (rem_r >= cfg.eff_slots) begin
          rem_r <= rem_r - cfg.eff_slots;
        end else begin
          rcp_busy_r <= 1'b0;
          wmod_r     <= rem_r;
        end
      end
    end
  end

endmodule

// ===== rtl/tlrb_store.sv =====
// ----------------------------------------------------------------------------
// tlrb_store: character and line length memories
// One write and one registered read per cycle on each memory. The line
// length memory is swept to zero after reset.
// ----------------------------------------------------------------------------
module tlrb_store #(
  parameter int MAX_LINE_LENGTH = 128,
  parameter int MAX_LINES       = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlrb_pkg::mem_req_t req,
  input  logic               rd_en,
  output logic [7:0]         rd_char,
  output logic [7:0]         rd_len,
  output logic               clr_busy
);

  localparam int DEPTH  = MAX_LINE_LENGTH * MAX_LINES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(MAX_LINES);

  logic [7:0] chr_mem [DEPTH];
  logic [7:0] len_mem [MAX_LINES];

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [SLOT_W-1:0] clr_cnt_r;
  logic              clr_busy_r;
  logic              len_we;
  logic [SLOT_W-1:0] len_waddr;
  logic [7:0]        len_wdata;
  logic [7:0]        rd_char_r;
  logic [7:0]        rd_len_r;

  assign waddr = ADDR_W'(req.chr_slot) * ADDR_W'(MAX_LINE_LENGTH) + ADDR_W'(req.chr_col);
  assign raddr = ADDR_W'(req.rd_slot) * ADDR_W'(MAX_LINE_LENGTH) + ADDR_W'(req.rd_col);

  assign len_we    = clr_busy_r || req.len_we;
  assign len_waddr = clr_busy_r ? clr_cnt_r : SLOT_W'(req.len_slot);
  assign len_wdata = clr_busy_r ? 8'd0 : req.len_data;

  assign clr_busy = clr_busy_r;
  assign rd_char  = rd_char_r;
  assign rd_len   = rd_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == SLOT_W'(MAX_LINES - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.chr_we) begin
      chr_mem[waddr] <= req.chr_data;
    end
    if (rd_en) begin
      rd_char_r <= chr_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (rd_en) begin
      rd_len_r <= len_mem[SLOT_W'(req.rd_slot)];
    end
  end

endmodule

// ===== rtl/text_line_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// text_line_ring_buffer_core: scrollback store of text lines in a ring
// Appends characters to the current line and reads characters of any
// visible line, one item per cycle while no backpressure or busy state holds.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per beat: an append of char_in, or a read of
//   (line_index, column). Every item gives exactly one beat on out_ch.
//   cfg_ch, always ready, writes line_length (index 0), lines_in_use (index 1);
//   write it only while no item is in flight; the block does not enforce it.
// Pipeline:
//   A result beat is offered through three registers: input register,
//   registered memory read, output register. One item is taken per cycle
//   while nothing stalls, bounded by the single write and read port of
//   each memory.
// Reset:
//   The line length memory is cleared one entry per cycle, all MAX_LINES
//   entries, with in_ch.ready low. After a register write the ring position
//   is re-reduced by repeated subtraction, with in_ch.ready low as well.
// Backpressure:
//   While out_ch holds a beat that is not taken, the whole pipeline holds
//   and in_ch.ready is low; nothing is dropped.
// ----------------------------------------------------------------------------
module text_line_ring_buffer_core #(
  parameter int MAX_LINE_LENGTH = 128,
  parameter int MAX_LINES       = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tlrb_in_if.sink     in_ch,
  tlrb_out_if.source  out_ch,
  tlrb_cfg_if.sink    cfg_ch
);

  tlrb_pkg::cfg_t     cfg;
  tlrb_pkg::mem_req_t req;
  tlrb_pkg::meta_t    meta;

  logic       adv;
  logic       accept;
  logic       busy;
  logic       rcp_busy;
  logic       clr_busy;
  logic [7:0] rd_char;
  logic [7:0] rd_len;

  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_char_r;
  logic [5:0] s1_idx_r;
  logic [6:0] s1_col_r;

  logic            s2_valid_r;
  tlrb_pkg::meta_t s2_meta_r;
  logic [7:0]      char_sel;

  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_idx_valid_r;
  logic [6:0] out_visible_r;
  logic [7:0] out_cursor_r;

  assign adv          = !out_valid_r || out_ch.ready;
  assign busy         = rcp_busy || clr_busy;
  assign in_ch.ready  = adv && !busy;
  assign accept       = in_ch.valid && in_ch.ready;

  tlrb_cfg #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .MAX_LINES       (MAX_LINES)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tlrb_cursor u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (adv && s1_valid_r),
    .operation  (s1_op_r),
    .char_in    (s1_char_r),
    .line_index (s1_idx_r),
    .column     (s1_col_r),
    .req        (req),
    .meta       (meta),
    .busy       (rcp_busy)
  );

  tlrb_store #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .MAX_LINES       (MAX_LINES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_en    (adv),
    .rd_char  (rd_char),
    .rd_len   (rd_len),
    .clr_busy (clr_busy)
  );

  // A column at or past the stored length, or an invalid index, reads as zero.
  assign char_sel = (s2_meta_r.idx_valid && ({1'b0, s2_meta_r.col} < rd_len)) ?
                    rd_char : tlrb_pkg::CHAR_NUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        s1_op_r   <= in_ch.operation;
        s1_char_r <= in_ch.char_in;
        s1_idx_r  <= in_ch.line_index;
        s1_col_r  <= in_ch.column;
      end
      s2_meta_r       <= meta;
      out_char_r      <= char_sel;
      out_idx_valid_r <= s2_meta_r.idx_valid;
      out_visible_r   <= s2_meta_r.visible;
      out_cursor_r    <= s2_meta_r.cursor;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.char_out      = out_char_r;
  assign out_ch.index_valid   = out_idx_valid_r;
  assign out_ch.visible_lines = out_visible_r;
  assign out_ch.cursor_column = out_cursor_r;

endmodule
